FILE: hdl/gbd_pkg.sv
package gbd_pkg;

  // Input actions
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_OUTSIDE = 2'd1;
  localparam logic [1:0] STS_NOCHG   = 2'd2;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Widths fixed by the fields and registers
  localparam int CFG_W  = 7;   // register width
  localparam int CRD_W  = 8;   // in-domain coordinate or dimension
  localparam int DST_W  = 9;   // one-axis distance, with a no-mark code
  localparam int CAP_W  = 7;   // cap = 1 + min(w, h) / 2
  localparam int QUO_W  = 16;  // Q1.15 quotient
  localparam int QUO_CW = 4;   // quotient bit counter

  localparam logic [DST_W-1:0] HD_NONE = {DST_W{1'b1}};

  typedef struct packed {
    logic [1:0]        action;
    logic signed [7:0] cell_x;
    logic signed [7:0] cell_y;
  } in_req_t;

  typedef struct packed {
    logic [5:0]  raw_distance;
    logic [15:0] normalized_distance;
    logic [1:0]  status;
  } out_res_t;

  // Map port control
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic             clr;
    logic [CRD_W-1:0] addr;
  } map_req_t;

  // Nearest mark within one row
  typedef struct packed {
    logic             vld;
    logic [DST_W-1:0] hdist;
    logic [CRD_W-1:0] row;
  } near_res_t;

endpackage

FILE: hdl/gbd_map.sv
module gbd_map #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gbd_pkg::map_req_t   req,
  input  logic [MAX_COLS-1:0] wdata,
  output logic [MAX_COLS-1:0] rdata
);
  import gbd_pkg::*;

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] rowv_r;
  logic [MAX_COLS-1:0] rdata_r;
  logic                rvld_r;
  logic [RIW-1:0]      addr;

  assign addr = req.addr[RIW-1:0];

  // Row storage, one row per access
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[addr];
    end
  end

  // Row valid bits: a row never written since a clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      rowv_r <= '0;
    end else if (req.wr) begin
      rowv_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else if (req.rd) begin
      rvld_r <= rowv_r[addr] && !req.clr;
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

FILE: hdl/gbd_near.sv
module gbd_near #(
  parameter int MAX_COLS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       row_vld,
  input  logic [MAX_COLS-1:0]        row_bits,
  input  logic [gbd_pkg::CRD_W-1:0]  row_idx,
  input  logic [gbd_pkg::CRD_W-1:0]  col_x,
  input  logic [gbd_pkg::CRD_W-1:0]  dim_w,
  output gbd_pkg::near_res_t         res
);
  import gbd_pkg::*;

  logic [MAX_COLS-1:0] left_m;
  logic [MAX_COLS-1:0] right_m;
  logic                lf;
  logic                rf;
  logic [DST_W-1:0]    lp;
  logic [DST_W-1:0]    rp;
  logic [DST_W-1:0]    hd_l;
  logic [DST_W-1:0]    hd_r;
  near_res_t           res_r;

  // Split the row at the query column, dropping columns outside the domain
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      left_m[i]  = row_bits[i] && (i <= int'(col_x)) && (i < int'(dim_w));
      right_m[i] = row_bits[i] && (i >= int'(col_x)) && (i < int'(dim_w));
    end
  end

  // Find the nearest mark on each side
  always_comb begin
    lf = 1'b0;
    lp = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (left_m[i]) begin
        lf = 1'b1;
        lp = DST_W'(i);
      end
    end
  end

  always_comb begin
    rf = 1'b0;
    rp = '0;
    for (int i = MAX_COLS - 1; i >= 0; i--) begin
      if (right_m[i]) begin
        rf = 1'b1;
        rp = DST_W'(i);
      end
    end
  end

  assign hd_l = lf ? ({1'b0, col_x} - lp) : HD_NONE;
  assign hd_r = rf ? (rp - {1'b0, col_x}) : HD_NONE;

  // Register the row result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else begin
      res_r.vld <= row_vld;
    end
    res_r.hdist <= (hd_l < hd_r) ? hd_l : hd_r;
    res_r.row   <= row_idx;
  end

  assign res = res_r;

endmodule

FILE: hdl/gbd_div.sv
module gbd_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [gbd_pkg::CAP_W-1:0] num,
  input  logic [gbd_pkg::CAP_W-1:0] den,
  output logic                      done,
  output logic [gbd_pkg::QUO_W-1:0] quot
);
  import gbd_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [QUO_CW-1:0]   cnt_r;
  logic [CAP_W:0]      rem_r;
  logic [CAP_W-1:0]    den_r;
  logic [QUO_W-1:0]    q_r;
  logic [CAP_W:0]      trial;
  logic                ge;

  // First step compares the numerator itself, later steps shift in a zero
  assign trial = (cnt_r == '0) ? rem_r : {rem_r[CAP_W-1:0], 1'b0};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {QUO_CW{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (trial - {1'b0, den_r}) : trial;
      q_r   <= {q_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: hdl/grid_boundary_distance.sv
// Boundary map over a grid with Manhattan distance queries.
// Input channel in_valid/in_stall/in_req carries one request: add or remove
// a boundary cell, query the capped distance from a cell to the nearest
// boundary or frame cell, or clear the whole map. Every request gives one
// result on out_valid/out_stall/out_res: raw distance, distance over cap in
// unsigned Q1.15, and a status code.
// The cfg port sets the grid width and height; write it only while idle.
// One request is in work at a time; in_stall is low only when the block is
// idle and out of reset, and it may take the next request while a result waits.
// Path from accept to result valid: clear or outside cell go through decode
// and finish, add or remove through decode, read-modify-write and finish,
// a query through decode, scan, divide and finish (h = grid height in use):
// the query reads the map one row per cycle over h rows and then runs
// a bit-serial divider for the Q1.15 fraction, one quotient bit per cycle.
// The next request is taken in the cycle after the result loads.
// Reset empties the map at once through per-row valid bits and sets both
// dimensions to 64. A stalled result holds in the output register, and the
// block holds the next finished result until that register frees.
module grid_boundary_distance #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  gbd_pkg::in_req_t          in_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output gbd_pkg::out_res_t         out_res,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [gbd_pkg::CFG_W-1:0] cfg_wdata
);
  import gbd_pkg::*;

  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RMW    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] cfg_w_r, cfg_h_r;
  logic [1:0]       act_r;
  logic [CRD_W-1:0] x_r, y_r;
  logic             xneg_r, yneg_r;
  logic [CRD_W-1:0] w_r, h_r;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [DST_W-1:0] best_r, best_nxt;
  logic [CRD_W-1:0] ridx_r, ridx_nxt;
  logic [CRD_W-1:0] prow_r, prow_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [5:0]       raw_r, raw_nxt;
  logic [QUO_W-1:0] norm_r, norm_nxt;
  logic [1:0]       sts_r, sts_nxt;
  logic             out_valid_r;
  out_res_t         out_res_r;

  logic             in_acc;
  logic             out_free;
  logic             in_domain;
  logic [CRD_W-1:0] dim_min;
  logic [CAP_W-1:0] cap_c;
  logic [DST_W-1:0] fr_x0, fr_y0, fr_x1, fr_y1, fr_min;
  logic [CRD_W-1:0] vd;
  logic [DST_W:0]   tot;
  logic             issue;
  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] div_quot;
  logic [CIW-1:0]   xc;
  map_req_t         mreq;
  logic [MAX_COLS-1:0] m_rdata, m_wdata;
  near_res_t        nr;

  function automatic logic [CRD_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input int maxv);
    logic [CRD_W-1:0] r;
    if (v == '0) begin
      r = CRD_W'(1);
    end else if (int'(v) > maxv) begin
      r = CRD_W'(maxv);
    end else begin
      r = {1'b0, v};
    end
    return r;
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign out_free = !out_valid_r || !out_stall;
  assign xc       = x_r[CIW-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= CFG_W'(64);
      cfg_h_r <= CFG_W'(64);
    end else if (cfg_we) begin
      if (cfg_idx == REG_WIDTH) begin
        cfg_w_r <= cfg_wdata;
      end else begin
        cfg_h_r <= cfg_wdata;
      end
    end
  end

  // Domain test, cap and frame distance
  assign in_domain = !xneg_r && !yneg_r && (x_r < w_r) && (y_r < h_r);
  assign dim_min = (w_r < h_r) ? w_r : h_r;
  assign cap_c   = CAP_W'(dim_min >> 1) + CAP_W'(1);
  assign fr_x0   = {1'b0, x_r} + DST_W'(1);
  assign fr_y0   = {1'b0, y_r} + DST_W'(1);
  assign fr_x1   = {1'b0, w_r} - {1'b0, x_r};
  assign fr_y1   = {1'b0, h_r} - {1'b0, y_r};

  always_comb begin
    fr_min = {2'b0, cap_c};
    if (fr_x0 < fr_min) fr_min = fr_x0;
    if (fr_y0 < fr_min) fr_min = fr_y0;
    if (fr_x1 < fr_min) fr_min = fr_x1;
    if (fr_y1 < fr_min) fr_min = fr_y1;
  end

  // Full distance of the nearest mark in the row just searched
  assign vd  = (nr.row >= y_r) ? (nr.row - y_r) : (y_r - nr.row);
  assign tot = {1'b0, nr.hdist} + {2'b0, vd};

  assign issue = (state_r == S_SCAN) && (ridx_r < h_r);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cap_nxt     = cap_r;
    best_nxt    = best_r;
    ridx_nxt    = ridx_r;
    prow_nxt    = prow_r;
    rd_pend_nxt = 1'b0;
    raw_nxt     = raw_r;
    norm_nxt    = norm_r;
    sts_nxt     = sts_r;
    mreq        = '0;
    m_wdata     = m_rdata;
    div_start   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        raw_nxt  = '0;
        norm_nxt = '0;
        sts_nxt  = STS_DONE;
        if (act_r == ACT_CLEAR) begin
          mreq.clr  = 1'b1;
          state_nxt = S_FIN;
        end else if (!in_domain) begin
          sts_nxt   = STS_OUTSIDE;
          state_nxt = S_FIN;
        end else if (act_r == ACT_QUERY) begin
          cap_nxt   = cap_c;
          best_nxt  = fr_min;
          ridx_nxt  = '0;
          state_nxt = S_SCAN;
        end else begin
          mreq.rd   = 1'b1;
          mreq.addr = y_r;
          state_nxt = S_RMW;
        end
      end
      S_RMW: begin
        // Set or clear the bit and write the row back on a change
        m_wdata[xc] = (act_r == ACT_ADD);
        mreq.addr   = y_r;
        if (m_rdata[xc] == (act_r == ACT_ADD)) begin
          sts_nxt = STS_NOCHG;
        end else begin
          mreq.wr = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_SCAN: begin
        if (issue) begin
          mreq.rd     = 1'b1;
          mreq.addr   = ridx_r;
          prow_nxt    = ridx_r;
          ridx_nxt    = ridx_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end
        if (nr.vld && (tot < {1'b0, best_r})) begin
          best_nxt = tot[DST_W-1:0];
        end
        if (!issue && !rd_pend_r && !nr.vld) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          raw_nxt   = best_r[5:0];
          norm_nxt  = div_quot;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // Latch the request and working values
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_req.action;
      x_r    <= {1'b0, in_req.cell_x[CRD_W-2:0]};
      y_r    <= {1'b0, in_req.cell_y[CRD_W-2:0]};
      xneg_r <= in_req.cell_x[CRD_W-1];
      yneg_r <= in_req.cell_y[CRD_W-1];
      w_r    <= clamp_dim(cfg_w_r, MAX_COLS);
      h_r    <= clamp_dim(cfg_h_r, MAX_ROWS);
    end
    cap_r  <= cap_nxt;
    best_r <= best_nxt;
    ridx_r <= ridx_nxt;
    prow_r <= prow_nxt;
    raw_r  <= raw_nxt;
    norm_r <= norm_nxt;
    sts_r  <= sts_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && out_free) begin
      out_res_r.raw_distance        <= raw_r;
      out_res_r.normalized_distance <= norm_r;
      out_res_r.status              <= sts_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  gbd_map #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .wdata (m_wdata),
    .rdata (m_rdata)
  );

  gbd_near #(
    .MAX_COLS(MAX_COLS)
  ) u_near (
    .clk      (clk),
    .rst_n    (rst_n),
    .row_vld  (rd_pend_r && (state_r == S_SCAN)),
    .row_bits (m_rdata),
    .row_idx  (prow_r),
    .col_x    (x_r),
    .dim_w    (w_r),
    .res      (nr)
  );

  gbd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (best_r[CAP_W-1:0]),
    .den   (cap_r),
    .done  (div_done),
    .quot  (div_quot)
  );

`ifndef SYNTH
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mreq.rd && mreq.wr))
    else $error("map read and write in the same cycle");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_DECODE))
    else $error("accepted request not decoded");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_best_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (best_r <= {2'b0, cap_r}))
    else $error("distance above cap");

  a_row_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    nr.vld |-> (state_r == S_SCAN))
    else $error("row result outside the scan");
`endif

endmodule

FILE: bench/grid_boundary_distance_test.sv
`timescale 1ns / 1ps

module grid_boundary_distance_test;
  import gbd_pkg::*;

  localparam int DIM_MAX     = 64;
  localparam int LONG_HOLD   = 400;
  localparam int END_WAIT    = 100;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 30;
  localparam int PHASE_ITEMS = 135;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_res;
  logic     cfg_we = 1'b0;
  logic     cfg_idx = REG_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Shadow of the block: register values as written, boundary marks
  logic [CFG_W-1:0] grid_w = 7'd64;
  logic [CFG_W-1:0] grid_h = 7'd64;
  bit               marks [0:DIM_MAX-1][0:DIM_MAX-1];

  in_req_t  request_queue [$];
  out_res_t expected_results [$];

  int  gap_left;
  int  stall_left;
  int  hold_left;
  bit  hold_kick;
  bit  hold_seen;
  bit  no_idle;
  int  mismatch_count;
  int  results_checked;
  int  n_query, n_edit, n_clear, n_outside, n_settings;
  int  cycles_run;
  int  spot_x, spot_y;

  grid_boundary_distance u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Dimension in use: zero counts as one, oversize counts as the maximum
  function automatic int eff_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return int'(v);
  endfunction

  // Apply one request to the shadow map and return the result it gives
  function automatic out_res_t apply_request(in_req_t r);
    int x, y, w, h, cap, best, d;
    out_res_t res;
    x = $signed(r.cell_x);
    y = $signed(r.cell_y);
    w = eff_dim(grid_w);
    h = eff_dim(grid_h);
    res = '0;
    res.status = STS_DONE;
    if (r.action == ACT_CLEAR) begin
      foreach (marks[j, i]) marks[j][i] = 1'b0;
    end else if (x < 0 || y < 0 || x >= w || y >= h) begin
      res.status = STS_OUTSIDE;
    end else if (r.action == ACT_ADD) begin
      if (marks[y][x]) res.status = STS_NOCHG;
      else marks[y][x] = 1'b1;
    end else if (r.action == ACT_REMOVE) begin
      if (!marks[y][x]) res.status = STS_NOCHG;
      else marks[y][x] = 1'b0;
    end else begin
      cap  = 1 + ((w < h) ? w : h) / 2;
      best = cap;
      // frame cells one step outside the grid
      if (x + 1 < best) best = x + 1;
      if (y + 1 < best) best = y + 1;
      if (w - x < best) best = w - x;
      if (h - y < best) best = h - y;
      // marks inside the domain in use only
      for (int j = 0; j < h; j++) begin
        for (int i = 0; i < w; i++) begin
          if (marks[j][i]) begin
            d = (i > x ? i - x : x - i) + (j > y ? j - y : y - j);
            if (d < best) best = d;
          end
        end
      end
      res.raw_distance        = best[5:0];
      res.normalized_distance = 16'((best * 32768) / cap);
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Driver: offer queued requests, hold each until accepted, idle at random between
  always @(posedge clk) begin : drive_requests
    logic     offer;
    out_res_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        res = apply_request(in_req);
        expected_results.insert(expected_results.size(), res);
        if (res.status == STS_OUTSIDE) n_outside++;
        if (in_req.action == ACT_QUERY) n_query++;
        else if (in_req.action == ACT_CLEAR) n_clear++;
        else n_edit++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (request_queue.size() > 0) begin
          in_req <= request_queue.pop_front();
          offer = 1'b1;
          gap_left <= (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        end
      end
      in_valid <= offer;
    end
  end

  // Monitor: stall at random, check each result against the oldest expectation
  always @(posedge clk) begin : check_results
    out_res_t want;
    int       nxt_stall;
    int       nxt_hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_seen  <= hold_kick;
    end else begin
      nxt_stall = stall_left;
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: raw %0d norm %0d status %0d",
                                    out_res.raw_distance, out_res.normalized_distance,
                                    out_res.status));
        end else begin
          want = expected_results.pop_front();
          if (out_res.raw_distance !== want.raw_distance)
            report_mismatch($sformatf("raw_distance got %0d want %0d",
                                      out_res.raw_distance, want.raw_distance));
          if (out_res.normalized_distance !== want.normalized_distance)
            report_mismatch($sformatf("normalized_distance got %0d want %0d",
                                      out_res.normalized_distance, want.normalized_distance));
          if (out_res.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_res.status, want.status));
        end
        nxt_stall = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end else if (out_valid && stall_left > 0) begin
        nxt_stall = stall_left - 1;
      end
      // long hold-off, started by a toggle from the sequencer
      nxt_hold = hold_left;
      if (hold_kick != hold_seen) begin
        hold_seen <= hold_kick;
        nxt_hold = LONG_HOLD;
      end else if (hold_left > 0) begin
        nxt_hold = hold_left - 1;
      end
      hold_left  <= nxt_hold;
      stall_left <= nxt_stall;
      out_stall  <= (nxt_stall > 0) || (nxt_hold > 0);
    end
  end

  task automatic queue_request(logic [1:0] act, int x, int y);
    in_req_t r;
    r.action = act;
    r.cell_x = x[7:0];
    r.cell_y = y[7:0];
    request_queue.insert(request_queue.size(), r);
  endtask

  // Mostly in-domain cells and frame cells, some clustered near the last mark
  task automatic queue_random(int count);
    int w, h, x, y, pick;
    logic [1:0] act;
    w = eff_dim(grid_w);
    h = eff_dim(grid_h);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 36) act = ACT_ADD;
      else if (pick < 52) act = ACT_REMOVE;
      else if (pick < 98) act = ACT_QUERY;
      else act = ACT_CLEAR;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
        x -= 128;
        y -= 128;
      end else if (pick < 40) begin
        x = $urandom_range(0, 6);
        y = $urandom_range(0, 6);
        x += spot_x - 3;
        y += spot_y - 3;
      end else begin
        x = $urandom_range(0, w + 1);
        y = $urandom_range(0, h + 1);
        x -= 1;
        y -= 1;
      end
      if (act == ACT_ADD) begin
        spot_x = x;
        spot_y = y;
      end
      queue_request(act, x, y);
    end
  endtask

  // Wait until every request is out and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Write both dimensions; call only while idle
  task automatic set_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_WIDTH;
    cfg_wdata <= w;
    grid_w = w;
    @(posedge clk);
    cfg_idx   <= REG_HEIGHT;
    cfg_wdata <= h;
    grid_h = h;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
    @(negedge clk);
  endtask

  initial begin : run_phases
    logic [CFG_W-1:0] w, h;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every action, frame and outside cells, at reset size
    queue_request(ACT_QUERY, 32, 32);
    queue_request(ACT_QUERY, 0, 0);
    queue_request(ACT_QUERY, 63, 63);
    queue_request(ACT_QUERY, 64, 0);
    queue_request(ACT_QUERY, -1, -1);
    queue_request(ACT_QUERY, 127, -128);
    queue_request(ACT_ADD, -128, 127);
    queue_request(ACT_ADD, -1, 10);
    queue_request(ACT_REMOVE, 10, 64);
    queue_request(ACT_ADD, 30, 30);
    queue_request(ACT_ADD, 30, 30);
    queue_request(ACT_QUERY, 33, 31);
    queue_request(ACT_REMOVE, 30, 30);
    queue_request(ACT_REMOVE, 30, 30);
    queue_request(ACT_ADD, 0, 63);
    queue_request(ACT_CLEAR, -1, 64);
    queue_request(ACT_REMOVE, 0, 63);
    queue_request(ACT_ADD, 50, 50);
    queue_request(ACT_ADD, 63, 0);
    wait_idle();

    // Shrink the grid: the mark at 50,50 lies outside and must be ignored
    set_grid(7'd20, 7'd20);
    queue_request(ACT_QUERY, 10, 10);
    queue_request(ACT_QUERY, 19, 19);
    queue_request(ACT_ADD, 50, 50);
    wait_idle();

    // Grow back: the kept mark counts again
    set_grid(7'd64, 7'd64);
    queue_request(ACT_QUERY, 50, 52);
    queue_request(ACT_QUERY, 63, 1);
    queue_request(ACT_QUERY, 31, 0);
    wait_idle();

    // Random phases over several sizes, out-of-range register values included
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin w = 7'd64;  h = 7'd64;  end
        1: begin w = 7'd0;   h = 7'd0;   end
        2: begin w = 7'd127; h = 7'd1;   end
        3: begin w = 7'd1;   h = 7'd127; end
        4: begin w = 7'd5;   h = 7'd9;   end
        5: begin w = 7'd33;  h = 7'd17;  end
        6: begin w = 7'd64;  h = 7'd2;   end
        7: begin w = 7'd100; h = 7'd64;  end
        8: begin w = 7'($urandom_range(1, 64)); h = 7'($urandom_range(1, 64)); end
        default: begin w = 7'd64; h = 7'd64; end
      endcase
      set_grid(w, h);
      spot_x = eff_dim(grid_w) / 2;
      spot_y = eff_dim(grid_h) / 2;
      @(posedge clk);
      no_idle <= (p == 0 || p == 6);
      if (p == 5 || p == 9) hold_kick <= ~hold_kick;
      @(negedge clk);
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    repeat (END_WAIT) @(posedge clk);
    $display("Covered %0d requests over %0d grid settings:",
             n_query + n_edit + n_clear, n_settings + 1);
    $display("  %0d queries, %0d add/remove, %0d clears, %0d outside the grid.",
             n_query, n_edit, n_clear, n_outside);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding.",
             cycles_run, expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
hdl/gbd_pkg.sv
hdl/gbd_map.sv
hdl/gbd_near.sv
hdl/gbd_div.sv
hdl/grid_boundary_distance.sv
bench/grid_boundary_distance_test.sv
